FILE: hdl/wlr_pkg.sv
package wlr_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int TS_W         = 16;
    localparam int OUT_W        = 48;
    localparam int USED_W       = 7;
    localparam int FRAC_STEPS   = 17;

    localparam int S_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W   = 2 * OUT_W + USED_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int SI_W   = 2 * CNT_W;
    localparam int SII_W  = 3 * CNT_W;
    localparam int SY_W   = SAMPLE_BITS + CNT_W;
    localparam int SIY_W  = SAMPLE_BITS + 2 * CNT_W;
    localparam int DI_W   = 4 * CNT_W;
    localparam int NUM_W  = SAMPLE_BITS + 4 * CNT_W + 1;
    localparam int DEN_W  = DI_W + TS_W;
    localparam int MA_W   = SIY_W + 1;
    localparam int MB_W   = DI_W + 1;
    localparam int P_W    = MA_W + MB_W;
    localparam int DVD_W  = NUM_W + FRAC_STEPS;
    localparam int REM_W  = DEN_W + 1;
    localparam int DSTEP_W = $clog2(DVD_W + 1);
    localparam int MSTEP_W = 3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_FIT  = 1'b1;

    localparam logic DIV_SLOPE     = 1'b0;
    localparam logic DIV_INTERCEPT = 1'b1;

    localparam logic [MSTEP_W-1:0] MS_N_SII  = 3'd0;
    localparam logic [MSTEP_W-1:0] MS_SI_SI  = 3'd1;
    localparam logic [MSTEP_W-1:0] MS_N_SIY  = 3'd2;
    localparam logic [MSTEP_W-1:0] MS_SI_SY  = 3'd3;
    localparam logic [MSTEP_W-1:0] MS_SII_SY = 3'd4;
    localparam logic [MSTEP_W-1:0] MS_SI_SIY = 3'd5;
    localparam logic [MSTEP_W-1:0] MS_DI_TS  = 3'd6;
    localparam logic [MSTEP_W-1:0] MS_FLUSH  = 3'd7;

    typedef struct packed {
        logic               push;
        logic               fit_start;
        logic               rd_en;
        logic [CNT_W-1:0]   rd_k;
        logic               mul_en;
        logic [MSTEP_W-1:0] mul_step;
        logic               div_start;
        logic               div_sel;
        logic               cap_q;
        logic               load_out;
        logic               fit_ok;
    } wlr_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic             ts_zero;
        logic             div_done;
        logic             out_free;
    } wlr_status_t;

endpackage

FILE: hdl/wlr_div.sv
module wlr_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [wlr_pkg::NUM_W-1:0]  num,
    input  logic [wlr_pkg::DEN_W-1:0]         den,
    output logic                              done,
    output logic [wlr_pkg::OUT_W-1:0]         q
);

    logic                             busy_reg;
    logic                             fin_reg;
    logic                             done_reg;
    logic [wlr_pkg::DSTEP_W-1:0]      cnt_reg;
    logic                             neg_reg;
    logic [wlr_pkg::DVD_W-1:0]        dvd_reg;
    logic [wlr_pkg::REM_W-1:0]        rem_reg;
    logic [wlr_pkg::DVD_W-1:0]        quo_reg;
    logic [wlr_pkg::DEN_W-1:0]        den_reg;
    logic [wlr_pkg::OUT_W-1:0]        q_reg;

    logic [wlr_pkg::NUM_W-1:0]        mag;
    logic [wlr_pkg::REM_W-1:0]        r_sh;
    logic                             ge;
    logic [wlr_pkg::DVD_W:0]          rnd_full;
    logic [wlr_pkg::DVD_W-1:0]        rnd;
    logic [wlr_pkg::DVD_W-1:0]        lim;
    logic [wlr_pkg::DVD_W-1:0]        sat;
    logic [wlr_pkg::OUT_W-1:0]        q_next;

    assign mag  = num[wlr_pkg::NUM_W-1] ? wlr_pkg::NUM_W'(-num) : wlr_pkg::NUM_W'(num);
    assign r_sh = {rem_reg[wlr_pkg::REM_W-2:0], dvd_reg[wlr_pkg::DVD_W-1]};
    assign ge   = r_sh >= {1'b0, den_reg};

    // Round half away from zero on the extra fraction bit, then clamp to the Q32.16 range.
    assign rnd_full = {1'b0, quo_reg} + 1'b1;
    assign rnd      = rnd_full[wlr_pkg::DVD_W:1];
    assign lim      = neg_reg ? (wlr_pkg::DVD_W'(1) << (wlr_pkg::OUT_W - 1))
                              : ((wlr_pkg::DVD_W'(1) << (wlr_pkg::OUT_W - 1)) - 1'b1);
    assign sat      = (rnd > lim) ? lim : rnd;
    assign q_next   = neg_reg ? wlr_pkg::OUT_W'(-sat[wlr_pkg::OUT_W-1:0])
                              : sat[wlr_pkg::OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == wlr_pkg::DSTEP_W'(wlr_pkg::DVD_W - 1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {mag, {wlr_pkg::FRAC_STEPS{1'b0}}};
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= num[wlr_pkg::NUM_W-1];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? r_sh - {1'b0, den_reg} : r_sh;
            quo_reg <= {quo_reg[wlr_pkg::DVD_W-2:0], ge};
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (fin_reg) begin
            q_reg <= q_next;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

FILE: hdl/wlr_datapath.sv
module wlr_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wlr_pkg::wlr_cmd_t                    cmd,
    output wlr_pkg::wlr_status_t                 status,
    input  logic signed [wlr_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 cfg_wr_en,
    input  logic [wlr_pkg::TS_W-1:0]             cfg_wr_data,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [wlr_pkg::OUT_W-1:0]            m_slope,
    output logic [wlr_pkg::OUT_W-1:0]            m_intercept,
    output logic                                 m_fit_valid,
    output logic [wlr_pkg::USED_W-1:0]           m_used
);

    logic signed [wlr_pkg::SAMPLE_BITS-1:0] mem [wlr_pkg::WINDOW_DEPTH];
    logic signed [wlr_pkg::SAMPLE_BITS-1:0] rd_data_reg;

    logic [wlr_pkg::IDX_W-1:0]   wp_reg;
    logic [wlr_pkg::CNT_W-1:0]   fill_reg;
    logic [wlr_pkg::TS_W-1:0]    ts_reg;
    logic [wlr_pkg::CNT_W-1:0]   n_reg;
    logic [wlr_pkg::IDX_W-1:0]   start_reg;
    logic                        rd_v_reg;
    logic [wlr_pkg::CNT_W-1:0]   rd_k_reg;

    logic [wlr_pkg::SI_W-1:0]          si_reg;
    logic [wlr_pkg::SII_W-1:0]         sii_reg;
    logic signed [wlr_pkg::SY_W-1:0]   sy_reg;
    logic signed [wlr_pkg::SIY_W-1:0]  siy_reg;

    logic signed [wlr_pkg::P_W-1:0]    prod_reg;
    logic                              mvalid_reg;
    logic [wlr_pkg::MSTEP_W-1:0]       mstep_d_reg;
    logic signed [wlr_pkg::NUM_W-1:0]  t_reg;
    logic [wlr_pkg::DI_W-1:0]          di_reg;
    logic signed [wlr_pkg::NUM_W-1:0]  num_s_reg;
    logic signed [wlr_pkg::NUM_W-1:0]  num_b_reg;
    logic [wlr_pkg::DEN_W-1:0]         den_s_reg;
    logic [wlr_pkg::OUT_W-1:0]         slope_reg;
    logic [wlr_pkg::OUT_W-1:0]         int_reg;

    logic                              m_tvalid_reg;
    logic [wlr_pkg::OUT_W-1:0]         m_slope_reg;
    logic [wlr_pkg::OUT_W-1:0]         m_int_reg;
    logic                              m_fit_reg;
    logic [wlr_pkg::USED_W-1:0]        m_used_reg;

    logic [wlr_pkg::CNT_W-1:0]         start_next;
    logic [wlr_pkg::CNT_W:0]           addr_sum;
    logic [wlr_pkg::IDX_W-1:0]         rd_addr;
    logic [2*wlr_pkg::CNT_W-1:0]       kk;
    logic signed [wlr_pkg::SAMPLE_BITS+wlr_pkg::CNT_W:0] ky;
    logic signed [wlr_pkg::MA_W-1:0]   ma;
    logic signed [wlr_pkg::MB_W-1:0]   mb;
    logic signed [wlr_pkg::NUM_W-1:0]  prod_t;
    logic signed [wlr_pkg::NUM_W-1:0]  div_num;
    logic [wlr_pkg::DEN_W-1:0]         div_den;
    logic                              div_done;
    logic [wlr_pkg::OUT_W-1:0]         div_q;

    assign start_next = ({1'b0, wp_reg} >= fill_reg)
                      ? {1'b0, wp_reg} - fill_reg
                      : {1'b0, wp_reg} + wlr_pkg::CNT_W'(wlr_pkg::WINDOW_DEPTH) - fill_reg;
    assign addr_sum   = {2'b00, start_reg} + {1'b0, cmd.rd_k};
    assign rd_addr    = (addr_sum >= (wlr_pkg::CNT_W + 1)'(wlr_pkg::WINDOW_DEPTH))
                      ? wlr_pkg::IDX_W'(addr_sum - (wlr_pkg::CNT_W + 1)'(wlr_pkg::WINDOW_DEPTH))
                      : wlr_pkg::IDX_W'(addr_sum);

    assign kk = rd_k_reg * rd_k_reg;
    assign ky = $signed({1'b0, rd_k_reg}) * rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wp_reg] <= sample;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            ts_reg       <= wlr_pkg::TS_W'(1);
            rd_v_reg     <= 1'b0;
            mvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ts_reg <= cfg_wr_data;
            end
            if (cmd.push) begin
                wp_reg <= (wp_reg == wlr_pkg::IDX_W'(wlr_pkg::WINDOW_DEPTH - 1))
                        ? '0 : wp_reg + 1'b1;
                if (fill_reg != wlr_pkg::CNT_W'(wlr_pkg::WINDOW_DEPTH)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            rd_v_reg   <= cmd.rd_en;
            mvalid_reg <= cmd.mul_en;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cmd.mul_step)
            wlr_pkg::MS_N_SII: begin
                ma = wlr_pkg::MA_W'(sii_reg);
                mb = wlr_pkg::MB_W'(n_reg);
            end
            wlr_pkg::MS_SI_SI: begin
                ma = wlr_pkg::MA_W'(si_reg);
                mb = wlr_pkg::MB_W'(si_reg);
            end
            wlr_pkg::MS_N_SIY: begin
                ma = wlr_pkg::MA_W'(siy_reg);
                mb = wlr_pkg::MB_W'(n_reg);
            end
            wlr_pkg::MS_SI_SY: begin
                ma = wlr_pkg::MA_W'(sy_reg);
                mb = wlr_pkg::MB_W'(si_reg);
            end
            wlr_pkg::MS_SII_SY: begin
                ma = wlr_pkg::MA_W'(sy_reg);
                mb = wlr_pkg::MB_W'(sii_reg);
            end
            wlr_pkg::MS_SI_SIY: begin
                ma = wlr_pkg::MA_W'(siy_reg);
                mb = wlr_pkg::MB_W'(si_reg);
            end
            wlr_pkg::MS_DI_TS: begin
                ma = wlr_pkg::MA_W'(ts_reg);
                mb = wlr_pkg::MB_W'(di_reg);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_t = wlr_pkg::NUM_W'(prod_reg);

    always_ff @(posedge aclk) begin
        rd_k_reg <= cmd.rd_k;
        if (cmd.fit_start) begin
            n_reg     <= fill_reg;
            start_reg <= wlr_pkg::IDX_W'(start_next);
            si_reg    <= '0;
            sii_reg   <= '0;
            sy_reg    <= '0;
            siy_reg   <= '0;
        end else if (rd_v_reg) begin
            si_reg  <= si_reg + wlr_pkg::SI_W'(rd_k_reg);
            sii_reg <= sii_reg + wlr_pkg::SII_W'(kk);
            sy_reg  <= sy_reg + wlr_pkg::SY_W'(rd_data_reg);
            siy_reg <= siy_reg + wlr_pkg::SIY_W'(ky);
        end

        if (cmd.mul_en) begin
            prod_reg    <= ma * mb;
            mstep_d_reg <= cmd.mul_step;
        end
        if (mvalid_reg) begin
            case (mstep_d_reg) inside
                wlr_pkg::MS_N_SII, wlr_pkg::MS_N_SIY, wlr_pkg::MS_SII_SY: t_reg <= prod_t;
                wlr_pkg::MS_SI_SI:  di_reg    <= wlr_pkg::DI_W'(t_reg - prod_t);
                wlr_pkg::MS_SI_SY:  num_s_reg <= t_reg - prod_t;
                wlr_pkg::MS_SI_SIY: num_b_reg <= t_reg - prod_t;
                wlr_pkg::MS_DI_TS:  den_s_reg <= wlr_pkg::DEN_W'(prod_reg);
                default: ;
            endcase
        end

        if (cmd.cap_q) begin
            if (cmd.div_sel == wlr_pkg::DIV_INTERCEPT) begin
                int_reg <= div_q;
            end else begin
                slope_reg <= div_q;
            end
        end

        if (cmd.load_out) begin
            m_slope_reg <= cmd.fit_ok ? slope_reg : '0;
            m_int_reg   <= cmd.fit_ok ? int_reg : '0;
            m_fit_reg   <= cmd.fit_ok;
            m_used_reg  <= wlr_pkg::USED_W'(n_reg);
        end
    end

    assign div_num = (cmd.div_sel == wlr_pkg::DIV_INTERCEPT) ? num_b_reg : num_s_reg;
    assign div_den = (cmd.div_sel == wlr_pkg::DIV_INTERCEPT) ? wlr_pkg::DEN_W'(di_reg)
                                                              : den_s_reg;

    wlr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .q       (div_q)
    );

    assign status.fill     = fill_reg;
    assign status.ts_zero  = (ts_reg == '0);
    assign status.div_done = div_done;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid    = m_tvalid_reg;
    assign m_slope     = m_slope_reg;
    assign m_intercept = m_int_reg;
    assign m_fit_valid = m_fit_reg;
    assign m_used      = m_used_reg;

endmodule

FILE: hdl/wlr_ctrl.sv
module wlr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_op,
    output logic                 s_tready,
    input  wlr_pkg::wlr_status_t status,
    output wlr_pkg::wlr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DRAIN,
        S_MUL,
        S_DIV_S,
        S_WAIT_S,
        S_DIV_B,
        S_WAIT_B,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [wlr_pkg::CNT_W-1:0]   k_reg;
    logic [wlr_pkg::MSTEP_W-1:0] mstep_reg;
    logic                        ok_reg;
    logic                        idle;

    assign idle     = (state_reg == S_IDLE);
    assign s_tready = idle;

    always_comb begin
        cmd           = '0;
        cmd.push      = idle && s_tvalid && (s_op == wlr_pkg::OP_PUSH);
        cmd.fit_start = idle && s_tvalid && (s_op == wlr_pkg::OP_FIT);
        cmd.rd_en     = (state_reg == S_ACC);
        cmd.rd_k      = k_reg;
        cmd.mul_en    = (state_reg == S_MUL);
        cmd.mul_step  = mstep_reg;
        cmd.div_start = (state_reg == S_DIV_S) || (state_reg == S_DIV_B);
        cmd.div_sel   = ((state_reg == S_DIV_B) || (state_reg == S_WAIT_B))
                      ? wlr_pkg::DIV_INTERCEPT : wlr_pkg::DIV_SLOPE;
        cmd.cap_q     = ((state_reg == S_WAIT_S) || (state_reg == S_WAIT_B)) && status.div_done;
        cmd.load_out  = (state_reg == S_OUT) && status.out_free;
        cmd.fit_ok    = ok_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            mstep_reg <= '0;
            ok_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_op == wlr_pkg::OP_FIT) begin
                        k_reg <= '0;
                        if (status.fill >= wlr_pkg::CNT_W'(2) && !status.ts_zero) begin
                            ok_reg    <= 1'b1;
                            state_reg <= S_ACC;
                        end else begin
                            ok_reg    <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_ACC: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == status.fill - 1'b1) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    mstep_reg <= wlr_pkg::MS_N_SII;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == wlr_pkg::MS_FLUSH) begin
                        state_reg <= S_DIV_S;
                    end
                end
                S_DIV_S: state_reg <= S_WAIT_S;
                S_WAIT_S: begin
                    if (status.div_done) begin
                        state_reg <= S_DIV_B;
                    end
                end
                S_DIV_B: state_reg <= S_WAIT_B;
                S_WAIT_B: begin
                    if (status.div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/window_linear_regression.sv
// Least-squares line fit over a circular window of the last 64 signed samples.
// A beat with tuser 0 pushes the sample in tdata into the window; it gives no
// output beat. A beat with tuser 1 requests a fit over the window, oldest sample first,
// with x spaced by time_step, and gives one output beat carrying slope and intercept
// in signed Q32.16 with saturation, the number of samples used, and a valid flag in
// tuser that is low when fewer than two samples are held or time_step is zero.
// A fit occupies the block: it reads one window entry per cycle through the sample
// memory read port, then uses the shared multiplier, then runs two 62-step bit-serial
// divisions. Pushes are accepted while a finished fit's output beat waits on the sink,
// but not while a fit waits for the output register. time_step resets to 1.
module window_linear_regression (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wlr_pkg::S_TDATA_W-1:0]     s_tdata,   // sample
    input  logic                              s_tuser,   // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wlr_pkg::M_TDATA_W-1:0]     m_tdata,   // slope, intercept, samples_used
    output logic                              m_tuser,   // fit_valid
    input  logic                              cfg_wr_en,
    input  logic [wlr_pkg::TS_W-1:0]          cfg_wr_data
);

    localparam int M_PAD_W = wlr_pkg::M_TDATA_W - wlr_pkg::M_FIELDS_W;

    wlr_pkg::wlr_cmd_t                cmd;
    wlr_pkg::wlr_status_t             status;
    logic [wlr_pkg::OUT_W-1:0]        slope;
    logic [wlr_pkg::OUT_W-1:0]        intercept;
    logic [wlr_pkg::USED_W-1:0]       used;

    wlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wlr_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .sample      (s_tdata[wlr_pkg::SAMPLE_BITS-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_slope     (slope),
        .m_intercept (intercept),
        .m_fit_valid (m_tuser),
        .m_used      (used)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, used, intercept, slope};

endmodule

FILE: hdl/wlr_checker.sv
module wlr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wlr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    localparam int USED_LO = 2 * wlr_pkg::OUT_W;

    // An output beat held back by the sink keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // A fit that is not valid reports zero slope and intercept.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[USED_LO-1:0] == '0)
        else $error("invalid fit carries nonzero results");

    // A valid fit used at least two samples.
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser
            |-> m_tdata[USED_LO+wlr_pkg::USED_W-1:USED_LO] >= wlr_pkg::USED_W'(2))
        else $error("valid fit with fewer than two samples");

    // No output beat is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind window_linear_regression wlr_checker u_wlr_checker (.*);

FILE: dv/testbench.sv
module testbench;
    import wlr_pkg::*;

    typedef struct {
        logic [OUT_W-1:0]  slope;
        logic [OUT_W-1:0]  intercept;
        logic              fit_valid;
        logic [USED_W-1:0] used;
    } fit_result_t;

    class fit_scoreboard;
        logic signed [SAMPLE_BITS-1:0] window[WINDOW_DEPTH];
        int unsigned wr_pos;
        int unsigned fill;
        int unsigned step;
        fit_result_t pending_fits[$];
        int errors;
        int fits_seen;
        int valid_fits;

        function new();
            wr_pos = 0;
            fill = 0;
            step = 1;
            errors = 0;
            fits_seen = 0;
            valid_fits = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        // Rounds num/den to Q.16, nearest with ties away from zero, saturated.
        function logic [OUT_W-1:0] to_q16(longint num, longint unsigned den);
            logic neg;
            longint unsigned mag, q, r, qmax;
            neg = num < 0;
            mag = neg ? -num : num;
            qmax = (64'd1 << 47) - 1;
            q = mag / den;
            r = mag % den;
            if (q >= (64'd1 << 32)) begin
                q = neg ? qmax + 1 : qmax;
            end else begin
                for (int i = 0; i < FRAC_STEPS; i++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= den) begin
                        r = r - den;
                        q = q | 1;
                    end
                end
                q = (q + 1) >> 1;
                if (neg && q > qmax + 1) q = qmax + 1;
                if (!neg && q > qmax) q = qmax;
            end
            if (neg) q = -q;
            return q[OUT_W-1:0];
        endfunction

        function void note_input(logic op, logic [SAMPLE_BITS-1:0] sample);
            fit_result_t res;
            longint n, si, sii, sy, siy, y, di, num_s, num_b;
            int unsigned start;
            if (op == OP_PUSH) begin
                window[wr_pos] = sample;
                wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
                if (fill < WINDOW_DEPTH) fill++;
                return;
            end
            res.slope = '0;
            res.intercept = '0;
            res.fit_valid = 1'b0;
            res.used = fill[USED_W-1:0];
            n = fill;
            if (n >= 2 && step != 0) begin
                start = (wr_pos + WINDOW_DEPTH - fill) % WINDOW_DEPTH;
                si = 0; sii = 0; sy = 0; siy = 0;
                for (longint k = 0; k < n; k++) begin
                    y = window[(start + k) % WINDOW_DEPTH];
                    si += k;
                    sii += k * k;
                    sy += y;
                    siy += k * y;
                end
                di = n * sii - si * si;
                num_s = n * siy - si * sy;
                num_b = sii * sy - si * siy;
                res.slope = to_q16(num_s, di * step);
                res.intercept = to_q16(num_b, di);
                res.fit_valid = 1'b1;
            end
            pending_fits = {pending_fits, res};
        endfunction

        function void check(logic [M_TDATA_W-1:0] data, logic valid_flag);
            fit_result_t exp_res;
            if (pending_fits.size() == 0) begin
                $display("%0t: unexpected output beat tdata=%h tuser=%b", $time, data, valid_flag);
                errors++;
                return;
            end
            exp_res = pending_fits.pop_front();
            fits_seen++;
            if (exp_res.fit_valid) valid_fits++;
            if (data[OUT_W-1:0] !== exp_res.slope) begin
                $display("%0t: slope expected %h actual %h", $time, exp_res.slope,
                         data[OUT_W-1:0]);
                errors++;
            end
            if (data[2*OUT_W-1:OUT_W] !== exp_res.intercept) begin
                $display("%0t: intercept expected %h actual %h", $time, exp_res.intercept,
                         data[2*OUT_W-1:OUT_W]);
                errors++;
            end
            if (data[2*OUT_W+USED_W-1:2*OUT_W] !== exp_res.used) begin
                $display("%0t: samples_used expected %0d actual %0d", $time, exp_res.used,
                         data[2*OUT_W+USED_W-1:2*OUT_W]);
                errors++;
            end
            if (valid_flag !== exp_res.fit_valid) begin
                $display("%0t: fit_valid expected %b actual %b", $time, exp_res.fit_valid,
                         valid_flag);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_wr_en;
    logic [TS_W-1:0]      cfg_wr_data;

    fit_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    logic recv_hold;
    int beats_sent;
    longint cycles;

    window_linear_regression dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 4000000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
            if (!aresetn || recv_hold) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(logic op, logic [SAMPLE_BITS-1:0] sample);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= S_TDATA_W'(sample);
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, sample);
        beats_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain_and_write(logic [TS_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_fits.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.step = value;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return SAMPLE_BITS'($urandom_range(7)) - 16'd3;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(70, 1)) begin
                    send_beat(OP_PUSH, pick_sample());
                    sent++;
                end
            end else if ($urandom_range(7) == 0) begin
                send_beat(OP_FIT, SAMPLE_BITS'($urandom));
                sent++;
            end else begin
                send_beat(OP_PUSH, pick_sample());
                sent++;
            end
        end
    endtask

    initial begin
        logic [TS_W-1:0] steps[5];
        sb = new();
        send_idle_pct = 25;
        recv_idle_pct = 57;
        recv_hold = 1'b0;
        beats_sent = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_PUSH;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(OP_FIT, 16'h0000);
        send_beat(OP_PUSH, 16'h8000);
        send_beat(OP_FIT, 16'hffff);
        send_beat(OP_PUSH, 16'h7fff);
        send_beat(OP_FIT, 16'h0000);
        send_beat(OP_PUSH, 16'h8000);
        send_beat(OP_PUSH, 16'h7fff);
        send_beat(OP_FIT, 16'h0000);
        send_beat(OP_PUSH, 16'h0000);
        send_beat(OP_PUSH, 16'hffff);
        send_beat(OP_PUSH, 16'h0001);
        send_beat(OP_FIT, 16'h0000);

        steps[0] = 16'hffff;
        steps[1] = 16'h0000;
        steps[2] = TS_W'($urandom_range(65535, 2));
        steps[3] = 16'h0001;
        steps[4] = TS_W'($urandom_range(20, 2));
        for (int p = 0; p < 5; p++) begin
            drain_and_write(steps[p]);
            if (p >= 2) begin
                send_idle_pct = 57;
                recv_idle_pct = 25;
            end
            if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (3000) @(posedge aclk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            random_phase(375);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_fits.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        $display("Sent %0d input beats over five time_step settings, including zero and 65535.",
                 beats_sent);
        $display("Checked %0d fits, %0d of them valid.", sb.fits_seen, sb.valid_fits);
        if (sb.errors == 0 && sb.pending_fits.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

FILE: window_linear_regression.f
hdl/wlr_pkg.sv
hdl/wlr_div.sv
hdl/wlr_datapath.sv
hdl/wlr_ctrl.sv
hdl/window_linear_regression.sv
hdl/wlr_checker.sv
dv/testbench.sv
